// ----- rtl/qev_pkg.sv -----
// ----------------------------------------------------------------------------
// qev_pkg
// Shared widths, types and helpers of the four-channel x1 quadrature decoder
// with windowed velocity.
// ----------------------------------------------------------------------------
package qev_pkg;

    localparam int COUNT_WIDTH = 32;
    localparam int NUM_CH      = 4;
    localparam int TICK_W      = 32;
    localparam int DELTA_W     = 32;
    localparam int SPEED_W     = 56;
    localparam int SPEED_SHIFT = 8;
    localparam int SCALE_W     = 32;
    localparam int PROD_W      = COUNT_WIDTH + SCALE_W + 1;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 1;

    localparam logic [TICK_W-1:0]  WINDOW_LENGTH_RST = TICK_W'(100000);
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST   = SCALE_W'(36766);

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_WINDOW_LENGTH = 1'b0,
        REG_SPEED_SCALE   = 1'b1
    } cfg_reg_t;

    typedef logic signed [COUNT_WIDTH-1:0] count_t;

    typedef struct packed {
        count_t [NUM_CH-1:0] cnt;
    } counts_t;

    function automatic count_t sat_step(count_t v, logic dn);
        count_t cmax;
        count_t cmin;
        cmax = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
        cmin = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
        if (dn)
            return (v == cmin) ? v : count_t'(v - count_t'(1));
        else
            return (v == cmax) ? v : count_t'(v + count_t'(1));
    endfunction

    function automatic logic signed [DELTA_W-1:0] to_delta(count_t c);
        logic [COUNT_WIDTH+DELTA_W-1:0] ext;
        ext = {{DELTA_W{c[COUNT_WIDTH-1]}}, c};
        return ext[DELTA_W-1:0];
    endfunction

    function automatic logic signed [SPEED_W-1:0] to_speed(logic signed [PROD_W-1:0] p);
        logic [PROD_W+SPEED_W+SPEED_SHIFT-1:0] ext;
        ext = {{(SPEED_W+SPEED_SHIFT){p[PROD_W-1]}}, p};
        return ext[SPEED_SHIFT +: SPEED_W];
    endfunction

endpackage

// ----- rtl/quad_encoder_x1_velocity_window_core.sv -----
// ----------------------------------------------------------------------------
// quad_encoder_x1_velocity_window_core
// Four-channel x1 quadrature decoder with windowed edge counts and speeds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one request per pin sample:
//   A and B levels of four encoders and a microsecond tick. The first request
//   after reset only primes the block. Output channel (out_valid/out_ready)
//   carries one result per closed window: four counts and four Q.16 speeds.
//   Configuration (cfg_we/cfg_index/cfg_data) sets window_length and
//   speed_scale; write only while no request is in flight.
//   Throughput: one request per cycle while the queue is not full. A request
//   that closes a window passes its snapshot through the two-entry snapshot
//   queue, the multiply stage of the back end and then the output register.
//   When the receiver stalls, results back up through the output register,
//   the multiply stage and the queue; in_ready drops only once the queue is
//   full. Reset clears counts, priming, window start and the queue, and loads
//   window_length = 100000 and speed_scale = 36766.
// ----------------------------------------------------------------------------
module quad_encoder_x1_velocity_window_core
    import qev_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [NUM_CH-1:0]          a_levels,
    input  logic [NUM_CH-1:0]          b_levels,
    input  logic [TICK_W-1:0]          tick,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DELTA_W-1:0]  delta_0,
    output logic signed [DELTA_W-1:0]  delta_1,
    output logic signed [DELTA_W-1:0]  delta_2,
    output logic signed [DELTA_W-1:0]  delta_3,
    output logic signed [SPEED_W-1:0]  speed_0,
    output logic signed [SPEED_W-1:0]  speed_1,
    output logic signed [SPEED_W-1:0]  speed_2,
    output logic signed [SPEED_W-1:0]  speed_3,
    input  logic                       cfg_we,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

    logic [TICK_W-1:0]  window_length_reg;
    logic [SCALE_W-1:0] speed_scale_reg;

    logic    q_full;
    logic    push;
    counts_t push_data;
    logic    pop;
    logic    q_valid;
    counts_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WINDOW_LENGTH_RST;
            speed_scale_reg   <= SPEED_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_WINDOW_LENGTH: window_length_reg <= cfg_data[TICK_W-1:0];
                REG_SPEED_SCALE:   speed_scale_reg   <= cfg_data[SCALE_W-1:0];
                default:           ;
            endcase
        end
    end

    qev_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .a_levels      (a_levels),
        .b_levels      (b_levels),
        .tick          (tick),
        .window_length (window_length_reg),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    qev_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .rd_valid  (q_valid),
        .rd_data   (q_data)
    );

    qev_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .pop         (pop),
        .speed_scale (speed_scale_reg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .delta_0     (delta_0),
        .delta_1     (delta_1),
        .delta_2     (delta_2),
        .delta_3     (delta_3),
        .speed_0     (speed_0),
        .speed_1     (speed_1),
        .speed_2     (speed_2),
        .speed_3     (speed_3)
    );

endmodule

// ----- rtl/qev_front.sv -----
// ----------------------------------------------------------------------------
// qev_front
// Accepts pin samples, detects rising A edges, keeps the saturating window
// counts and hands a snapshot of the counts to the queue when a window closes.
// ----------------------------------------------------------------------------
module qev_front
    import qev_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [NUM_CH-1:0]   a_levels,
    input  logic [NUM_CH-1:0]   b_levels,
    input  logic [TICK_W-1:0]   tick,
    input  logic [TICK_W-1:0]   window_length,
    input  logic                q_full,
    output logic                push,
    output counts_t             push_data
);

    logic                primed_reg;
    logic [NUM_CH-1:0]   prev_a_reg;
    logic [TICK_W-1:0]   start_reg;
    count_t [NUM_CH-1:0] cnt_reg;

    logic                accept;
    logic [NUM_CH-1:0]   rising;
    logic [TICK_W-1:0]   elapsed;
    logic                crossed;
    count_t [NUM_CH-1:0] cnt_next;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign rising   = a_levels & ~prev_a_reg;
    assign elapsed  = tick - start_reg;
    assign crossed  = elapsed >= window_length;

    always_comb
    begin
        for (int i = 0; i < NUM_CH; i++)
        begin
            cnt_next[i] = rising[i] ? sat_step(cnt_reg[i], b_levels[i]) : cnt_reg[i];
        end
    end

    assign push          = accept && primed_reg && crossed;
    assign push_data.cnt = cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= 1'b0;
            prev_a_reg <= '0;
            start_reg  <= '0;
            cnt_reg    <= '0;
        end
        else if (accept)
        begin
            prev_a_reg <= a_levels;
            if (!primed_reg)
            begin
                primed_reg <= 1'b1;
                start_reg  <= tick;
            end
            else if (crossed)
            begin
                start_reg <= tick;
                cnt_reg   <= '0;
            end
            else
            begin
                cnt_reg <= cnt_next;
            end
        end
    end

endmodule

// ----- rtl/qev_queue.sv -----
// ----------------------------------------------------------------------------
// qev_queue
// Short queue of closed-window count snapshots between the front and the back.
// ----------------------------------------------------------------------------
module qev_queue
    import qev_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  counts_t push_data,
    output logic    full,
    input  logic    pop,
    output logic    rd_valid,
    output counts_t rd_data
);

    counts_t             mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   cnt_reg;

    assign full     = cnt_reg == QCNT_W'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              QPTR_W'(wr_ptr_reg + 1'b1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                              QPTR_W'(rd_ptr_reg + 1'b1);
            end
            if (push && !pop)
            begin
                cnt_reg <= QCNT_W'(cnt_reg + 1'b1);
            end
            else if (pop && !push)
            begin
                cnt_reg <= QCNT_W'(cnt_reg - 1'b1);
            end
        end
    end

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("qev_queue: push while full");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> rd_valid)
        else $error("qev_queue: pop while empty");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("qev_queue: occupancy beyond depth");

    a_cnt_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == QCNT_W'($past(cnt_reg) + 1'b1))
        else $error("qev_queue: occupancy did not advance on push");

endmodule

// ----- rtl/qev_back.sv -----
// ----------------------------------------------------------------------------
// qev_back
// Takes count snapshots from the queue, multiplies each count by the speed
// scale in a registered stage and presents counts and speeds in an output
// register.
// ----------------------------------------------------------------------------
module qev_back
    import qev_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       q_valid,
    input  counts_t                    q_data,
    output logic                       pop,
    input  logic [SCALE_W-1:0]         speed_scale,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [DELTA_W-1:0]  delta_0,
    output logic signed [DELTA_W-1:0]  delta_1,
    output logic signed [DELTA_W-1:0]  delta_2,
    output logic signed [DELTA_W-1:0]  delta_3,
    output logic signed [SPEED_W-1:0]  speed_0,
    output logic signed [SPEED_W-1:0]  speed_1,
    output logic signed [SPEED_W-1:0]  speed_2,
    output logic signed [SPEED_W-1:0]  speed_3
);

    logic                             s1_valid_reg;
    logic signed [PROD_W-1:0]         prod_reg  [NUM_CH];
    logic signed [DELTA_W-1:0]        s1_delta_reg [NUM_CH];
    logic                             out_valid_reg;
    logic signed [DELTA_W-1:0]        delta_reg [NUM_CH];
    logic signed [SPEED_W-1:0]        speed_reg [NUM_CH];

    logic                             s1_adv;
    logic signed [SCALE_W:0]          scale_s;

    assign s1_adv  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign pop     = q_valid && (!s1_valid_reg || s1_adv);
    assign scale_s = $signed({1'b0, speed_scale});

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                prod_reg[i]     <= PROD_W'($signed(q_data.cnt[i])) * PROD_W'(scale_s);
                s1_delta_reg[i] <= to_delta(q_data.cnt[i]);
            end
        end
        if (s1_adv)
        begin
            for (int i = 0; i < NUM_CH; i++)
            begin
                delta_reg[i] <= s1_delta_reg[i];
                speed_reg[i] <= to_speed(prod_reg[i]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign delta_0   = delta_reg[0];
    assign delta_1   = delta_reg[1];
    assign delta_2   = delta_reg[2];
    assign delta_3   = delta_reg[3];
    assign speed_0   = speed_reg[0];
    assign speed_1   = speed_reg[1];
    assign speed_2   = speed_reg[2];
    assign speed_3   = speed_reg[3];

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Testbench for the four-channel x1 quadrature decoder with windowed velocity.
// A scoreboard class predicts window counts and Q.16 speeds for each
// accepted pin sample. Monitored results are checked field by field. The
// stimulus is a directed pass over the extremes, then random quadrature walks
// with noise under several window and scale settings and idle patterns, plus
// one long receiver hold that backs the block up.
// ----------------------------------------------------------------------------
module tb;
    import qev_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN       = 8;

    typedef struct packed {
        logic [NUM_CH-1:0][DELTA_W-1:0] delta;
        logic [NUM_CH-1:0][SPEED_W-1:0] speed;
    } window_t;

    class edge_window_board;
        logic [TICK_W-1:0]               win_len;
        logic [SCALE_W-1:0]              scale;
        logic                            primed;
        logic [NUM_CH-1:0]               last_a;
        logic [TICK_W-1:0]               win_start;
        logic signed [COUNT_WIDTH-1:0]   counts [NUM_CH];
        window_t                         pending_windows [$];
        int                              faults;

        function new();
            win_len   = WINDOW_LENGTH_RST;
            scale     = SPEED_SCALE_RST;
            primed    = 1'b0;
            last_a    = '0;
            win_start = '0;
            faults    = 0;
            foreach (counts[ch])
                counts[ch] = '0;
        endfunction

        function void set_regs(logic [TICK_W-1:0] len, logic [SCALE_W-1:0] sc);
            win_len = len;
            scale   = sc;
        endfunction

        function int pending();
            return pending_windows.size();
        endfunction

        function logic signed [COUNT_WIDTH-1:0] step_count(
            logic signed [COUNT_WIDTH-1:0] v, logic down);
            logic signed [COUNT_WIDTH-1:0] top;
            logic signed [COUNT_WIDTH-1:0] bottom;
            top    = {1'b0, {(COUNT_WIDTH-1){1'b1}}};
            bottom = {1'b1, {(COUNT_WIDTH-1){1'b0}}};
            if (down)
                return (v == bottom) ? v : v - 1;
            return (v == top) ? v : v + 1;
        endfunction

        function void take_sample(logic [NUM_CH-1:0] a, logic [NUM_CH-1:0] b,
                                  logic [TICK_W-1:0] t);
            logic [NUM_CH-1:0]  rise;
            logic [TICK_W-1:0]  span;
            logic signed [95:0] prod;
            window_t            w;
            if (!primed)
            begin
                primed    = 1'b1;
                last_a    = a;
                win_start = t;
                return;
            end
            rise = a & ~last_a;
            for (int ch = 0; ch < NUM_CH; ch++)
                if (rise[ch])
                    counts[ch] = step_count(counts[ch], b[ch]);
            last_a = a;
            span   = t - win_start;
            if (span < win_len)
                return;
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                prod = $signed({{(96-COUNT_WIDTH){counts[ch][COUNT_WIDTH-1]}}, counts[ch]})
                     * $signed({{(96-SCALE_W){1'b0}}, scale});
                w.delta[ch] = counts[ch][DELTA_W-1:0];
                w.speed[ch] = prod[SPEED_SHIFT +: SPEED_W];
                counts[ch]  = '0;
            end
            win_start = t;
            pending_windows.push_back(w);
        endfunction

        function void match_window(window_t got);
            window_t want;
            if (pending_windows.size() == 0)
            begin
                faults++;
                $display("%0t: unexpected window, expected none, got delta_0 %0d",
                         $time, $signed(got.delta[0]));
                return;
            end
            want = pending_windows.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++)
            begin
                if (got.delta[ch] !== want.delta[ch])
                begin
                    faults++;
                    $display("%0t: delta_%0d expected %0d got %0d", $time, ch,
                             $signed(want.delta[ch]), $signed(got.delta[ch]));
                end
                if (got.speed[ch] !== want.speed[ch])
                begin
                    faults++;
                    $display("%0t: speed_%0d expected %0d got %0d", $time, ch,
                             $signed(want.speed[ch]), $signed(got.speed[ch]));
                end
            end
        endfunction
    endclass

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic [NUM_CH-1:0]         a_levels;
    logic [NUM_CH-1:0]         b_levels;
    logic [TICK_W-1:0]         tick;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [DELTA_W-1:0] delta_0;
    logic signed [DELTA_W-1:0] delta_1;
    logic signed [DELTA_W-1:0] delta_2;
    logic signed [DELTA_W-1:0] delta_3;
    logic signed [SPEED_W-1:0] speed_0;
    logic signed [SPEED_W-1:0] speed_1;
    logic signed [SPEED_W-1:0] speed_2;
    logic signed [SPEED_W-1:0] speed_3;
    logic                      cfg_we;
    logic [CFG_INDEX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]     cfg_data;

    edge_window_board board;
    window_t          seen_window;
    logic [1:0]       phase [NUM_CH];
    logic [TICK_W-1:0] clock_tick;
    int               send_idle_pct  = 0;
    int               recv_stall_pct = 0;
    int               hold_req       = 0;
    int               hold_seen      = 0;
    int               hold_left      = 0;
    int               cycle_count    = 0;

    quad_encoder_x1_velocity_window_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .a_levels  (a_levels),
        .b_levels  (b_levels),
        .tick      (tick),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .delta_0   (delta_0),
        .delta_1   (delta_1),
        .delta_2   (delta_2),
        .delta_3   (delta_3),
        .speed_0   (speed_0),
        .speed_1   (speed_1),
        .speed_2   (speed_2),
        .speed_3   (speed_3),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // hold off for a long stretch on request, else stall at random
    always @(negedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_window.delta[0] = delta_0;
            seen_window.delta[1] = delta_1;
            seen_window.delta[2] = delta_2;
            seen_window.delta[3] = delta_3;
            seen_window.speed[0] = speed_0;
            seen_window.speed[1] = speed_1;
            seen_window.speed[2] = speed_2;
            seen_window.speed[3] = speed_3;
            board.match_window(seen_window);
        end
    end

    task automatic send_sample(input logic [NUM_CH-1:0] a, input logic [NUM_CH-1:0] b,
                               input logic [TICK_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        a_levels <= a;
        b_levels <= b;
        tick     <= t;
        do
            @(posedge clk);
        while (!in_ready);
        board.take_sample(a, b, t);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge clk);
        repeat (DRAIN) @(negedge clk);
    endtask

    task automatic program_regs(input logic [TICK_W-1:0] len, input logic [SCALE_W-1:0] sc);
        settle();
        cfg_we    <= 1'b1;
        cfg_index <= REG_WINDOW_LENGTH;
        cfg_data  <= len;
        @(negedge clk);
        cfg_index <= REG_SPEED_SCALE;
        cfg_data  <= sc;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_regs(len, sc);
    endtask

    // quadrature walks per channel, with some noise samples and tick jumps
    task automatic random_samples(input int n, input int tick_step);
        logic [NUM_CH-1:0] a;
        logic [NUM_CH-1:0] b;
        int                mv;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(99) < 8)
            begin
                a = NUM_CH'($urandom);
                b = NUM_CH'($urandom);
                if ($urandom_range(1) == 1)
                    clock_tick = $urandom;
            end
            else
            begin
                for (int ch = 0; ch < NUM_CH; ch++)
                begin
                    mv = $urandom_range(2);
                    if (mv == 1)
                        phase[ch] = phase[ch] + 2'd1;
                    else if (mv == 2)
                        phase[ch] = phase[ch] - 2'd1;
                    a[ch] = (phase[ch] == 2'd1) || (phase[ch] == 2'd2);
                    b[ch] = phase[ch][1];
                end
                clock_tick = clock_tick + TICK_W'($urandom_range(tick_step));
            end
            send_sample(a, b, clock_tick);
        end
    endtask

    task automatic random_phases(input int n);
        program_regs($urandom_range(100, 3000), $urandom);
        random_samples(n, 400);
        program_regs($urandom_range(1, 40), $urandom_range(0, 32'h0300_0000));
        random_samples(n, 20);
        program_regs($urandom_range(0, 8), $urandom);
        random_samples(n, 6);
    endtask

    initial
    begin
        board     = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        a_levels  = '0;
        b_levels  = '0;
        tick      = '0;
        cfg_we    = 1'b0;
        cfg_index = REG_WINDOW_LENGTH;
        cfg_data  = '0;
        foreach (phase[ch])
            phase[ch] = 2'd0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset settings; priming sample lies past a window length from zero
        send_sample(4'b1010, 4'b0000, 32'h8000_0000);
        send_sample(4'b1111, 4'b0101, 32'h8000_000A);
        send_sample(4'b0000, 4'b1111, 32'h8000_0014);
        send_sample(4'b1111, 4'b0000, 32'h8001_869F);
        send_sample(4'b1111, 4'b1111, 32'h8001_86A0);

        // zero window, full scale: every sample closes a window
        program_regs(32'h0000_0000, 32'hFFFF_FFFF);
        send_sample(4'b0000, 4'b1111, 32'hFFFF_FFF0);
        send_sample(4'b1111, 4'b0000, 32'h0000_0005);
        send_sample(4'b0000, 4'b0000, 32'h0000_0009);
        send_sample(4'b1111, 4'b1111, 32'h0000_0009);
        send_sample(4'b1111, 4'b0000, 32'h0000_000C);

        // longest window: closes only at a distance of all ones
        program_regs(32'hFFFF_FFFF, 32'h0000_0001);
        send_sample(4'b0000, 4'b1100, 32'h0000_000A);
        send_sample(4'b1111, 4'b0011, 32'h0000_000B);

        program_regs(32'h0000_0001, 32'h0100_0000);
        send_sample(4'b0110, 4'b1001, 32'h0000_000B);
        send_sample(4'b0111, 4'b1000, 32'h0000_000C);
        clock_tick = 32'h0000_000C;

        send_idle_pct  = 22;
        recv_stall_pct = 54;
        random_phases(60);

        send_idle_pct  = 54;
        recv_stall_pct = 22;
        random_phases(60);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        program_regs(32'h0000_0000, $urandom);
        hold_req++;
        random_samples(40, 3);
        random_phases(50);

        settle();
        if (board.faults == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
